@@ hdl/kwm_pkg.sv @@
package kwm_pkg;

   // Largest number of lanes the lane field can address
   localparam int HW_LANES = 8;
   localparam int LANE_W = 3;
   localparam int CNT_W = 4;
   localparam int VALUE_W = 32;
   localparam int DEF_LANES = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [CNT_W-1:0] LANE_COUNT_RESET = 4'd8;

   // Result status codes
   localparam logic [1:0] ST_ELEM = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // Input item kinds
   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_END = 1'b1;

   typedef struct packed {
      logic kind;
      logic [LANE_W-1:0] lane;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [LANE_W-1:0] out_lane;
      logic signed [VALUE_W-1:0] out_value;
   } rsp_type;

   // Queue entry: the beat plus what the front already knows about it
   typedef struct packed {
      req_type req;
      logic range_bad;
   } cmd_type;

   // Clamp the programmed lane count to 1 .. used
   function automatic logic [CNT_W-1:0] active_lanes(input logic [CNT_W-1:0] cnt,
                                                     input logic [CNT_W-1:0] used);
      logic [CNT_W-1:0] n;
      n = cnt;
      if (n == '0) begin
         n = {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (n > used) begin
         n = used;
      end
      return n;
   endfunction

endpackage

@@ hdl/kwm_front.sv @@
module kwm_front #(
   parameter int LANES = kwm_pkg::DEF_LANES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  kwm_pkg::req_type req_data,
   input  logic [kwm_pkg::CNT_W-1:0] lane_count,
   output logic cmd_valid,
   input  logic cmd_pop,
   output kwm_pkg::cmd_type cmd_data
);
   import kwm_pkg::*;

   localparam int USED = (LANES < HW_LANES) ? LANES : HW_LANES;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic push;
   logic [CNT_W-1:0] n_active;
   cmd_type cmd_new;

   // Classify: lanes beyond the active count are rejected downstream
   always_comb begin
      n_active = active_lanes(lane_count, CNT_W'(USED));
      cmd_new.req = req_data;
      cmd_new.range_bad = ({1'b0, req_data.lane} >= n_active);
   end

   assign req_stall = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign cmd_data = queue_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ hdl/kwm_back.sv @@
module kwm_back #(
   parameter int LANES = kwm_pkg::DEF_LANES
) (
   input  logic clock,
   input  logic reset,
   input  logic [kwm_pkg::CNT_W-1:0] lane_count,
   input  logic merge_clear,
   input  logic cmd_valid,
   output logic cmd_pop,
   input  kwm_pkg::cmd_type cmd_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output kwm_pkg::rsp_type rsp_data
);
   import kwm_pkg::*;

   localparam int USED = (LANES < HW_LANES) ? LANES : HW_LANES;

   logic signed [VALUE_W-1:0] head_ff [USED];
   logic [USED-1:0] head_valid_ff, head_valid_in;
   logic [USED-1:0] lane_ended_ff, lane_ended_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic go;
   logic busy;
   logic all_ready;
   logic emit;
   logic [CNT_W-1:0] n_active;
   logic [USED-1:0] sel;
   logic [USED-1:0] hv_upd;
   logic [USED-1:0] en_upd;
   logic signed [VALUE_W-1:0] head_eff [USED];

   // Comparator tree over eight leaves, lowest lane wins ties
   logic signed [VALUE_W-1:0] t0_val [8];
   logic [LANE_W-1:0] t0_idx [8];
   logic t0_v [8];
   logic signed [VALUE_W-1:0] t1_val [4];
   logic [LANE_W-1:0] t1_idx [4];
   logic t1_v [4];
   logic signed [VALUE_W-1:0] t2_val [2];
   logic [LANE_W-1:0] t2_idx [2];
   logic t2_v [2];
   logic signed [VALUE_W-1:0] best_val;
   logic [LANE_W-1:0] best_idx;
   logic found;

   assign go = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign cmd_pop = go;

   // Check the lane and fold the new beat into the lane flags
   always_comb begin
      n_active = active_lanes(lane_count, CNT_W'(USED));
      busy = cmd_data.range_bad;
      for (int i = 0; i < USED; i++) begin
         sel[i] = (cmd_data.req.lane == LANE_W'(i));
         if (sel[i] && (head_valid_ff[i] || lane_ended_ff[i])) begin
            busy = 1'b1;
         end
      end
      all_ready = 1'b1;
      for (int i = 0; i < USED; i++) begin
         hv_upd[i] = head_valid_ff[i] ||
                     (sel[i] && !busy && (cmd_data.req.kind == KIND_VALUE));
         en_upd[i] = lane_ended_ff[i] ||
                     (sel[i] && !busy && (cmd_data.req.kind == KIND_END));
         head_eff[i] = (sel[i] && (cmd_data.req.kind == KIND_VALUE)) ?
                       cmd_data.req.value : head_ff[i];
         if ((CNT_W'(i) < n_active) && !hv_upd[i] && !en_upd[i]) begin
            all_ready = 1'b0;
         end
      end
   end

   // Pick the smallest valid head
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         t0_idx[i] = LANE_W'(i);
         t0_val[i] = '0;
         t0_v[i] = 1'b0;
      end
      for (int i = 0; i < USED; i++) begin
         t0_val[i] = head_eff[i];
         t0_v[i] = hv_upd[i];
      end
      for (int i = 0; i < 4; i++) begin
         if (t0_v[2*i+1] && (!t0_v[2*i] || (t0_val[2*i+1] < t0_val[2*i]))) begin
            t1_val[i] = t0_val[2*i+1];
            t1_idx[i] = t0_idx[2*i+1];
         end else begin
            t1_val[i] = t0_val[2*i];
            t1_idx[i] = t0_idx[2*i];
         end
         t1_v[i] = t0_v[2*i] || t0_v[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         if (t1_v[2*i+1] && (!t1_v[2*i] || (t1_val[2*i+1] < t1_val[2*i]))) begin
            t2_val[i] = t1_val[2*i+1];
            t2_idx[i] = t1_idx[2*i+1];
         end else begin
            t2_val[i] = t1_val[2*i];
            t2_idx[i] = t1_idx[2*i];
         end
         t2_v[i] = t1_v[2*i] || t1_v[2*i+1];
      end
      if (t2_v[1] && (!t2_v[0] || (t2_val[1] < t2_val[0]))) begin
         best_val = t2_val[1];
         best_idx = t2_idx[1];
      end else begin
         best_val = t2_val[0];
         best_idx = t2_idx[0];
      end
      found = t2_v[0] || t2_v[1];
   end

   // Decide the result and the next lane flags
   always_comb begin
      head_valid_in = head_valid_ff;
      lane_ended_in = lane_ended_ff;
      rsp_in = rsp_ff;
      emit = 1'b0;
      if (merge_clear) begin
         head_valid_in = '0;
         lane_ended_in = '0;
      end else if (go) begin
         if (busy) begin
            emit = 1'b1;
            rsp_in.status = ST_REJECT;
            rsp_in.out_lane = cmd_data.req.lane;
            rsp_in.out_value = '0;
         end else begin
            head_valid_in = hv_upd;
            lane_ended_in = en_upd;
            if (all_ready && found) begin
               emit = 1'b1;
               for (int i = 0; i < USED; i++) begin
                  if (best_idx == LANE_W'(i)) begin
                     head_valid_in[i] = 1'b0;
                  end
               end
               rsp_in.status = ST_ELEM;
               rsp_in.out_lane = best_idx;
               rsp_in.out_value = best_val;
            end else if (all_ready) begin
               emit = 1'b1;
               head_valid_in = '0;
               lane_ended_in = '0;
               rsp_in.status = ST_DONE;
               rsp_in.out_lane = '0;
               rsp_in.out_value = '0;
            end
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         lane_ended_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         lane_ended_ff <= lane_ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload and write new heads
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      for (int i = 0; i < USED; i++) begin
         if (go && !busy && sel[i] && (cmd_data.req.kind == KIND_VALUE)) begin
            head_ff[i] <= cmd_data.req.value;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ hdl/k_way_sorted_merge.sv @@
// An accepted beat is queued, then its result (if any) is held in the result register.
// Throughput: one beat per cycle unless rsp_stall holds the result; the back end
// updates one lane and runs the eight-leaf comparator tree for the minimum head.
// A two-entry queue lets the input side run while a result waits on rsp_stall.
// Reset (synchronous): queue and result register empty, all lane flags clear,
// lane_count back to 8; heads hold no value until written, no clearing pass.
module k_way_sorted_merge #(
   parameter int LANES = kwm_pkg::DEF_LANES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  kwm_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output kwm_pkg::rsp_type rsp_data,
   input  logic csr_write_en,
   input  logic [kwm_pkg::CNT_W-1:0] csr_write_data
);
   import kwm_pkg::*;

   logic [CNT_W-1:0] lane_count_ff;
   logic cmd_valid;
   logic cmd_pop;
   cmd_type cmd_data;

   // Hold the lane count register
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_count_ff <= LANE_COUNT_RESET;
      end else if (csr_write_en) begin
         lane_count_ff <= csr_write_data;
      end
   end

   kwm_front #(
      .LANES (LANES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .lane_count (lane_count_ff),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_data   (cmd_data)
   );

   kwm_back #(
      .LANES (LANES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .lane_count  (lane_count_ff),
      .merge_clear (csr_write_en),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
